// File: sv/incremental_pid_fixed_point_defines.svh
// Assertion macros for the incremental PID block.
// Used by the top level; expects clk and arst_n in scope at the point of use.
`ifndef INCREMENTAL_PID_FIXED_POINT_DEFINES_SVH
`define INCREMENTAL_PID_FIXED_POINT_DEFINES_SVH
`ifndef SYNTHESIS
`define IPID_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ipid assertion failed");
`define IPID_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ipid assertion failed");
`else
`define IPID_ASSERT_NOW(label, ante, cons)
`define IPID_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: sv/ipid_pkg.sv
// Shared constants and types for the incremental PID block.
// No dependencies; used by ipid_cfg, ipid_calc and the top level.
package ipid_pkg;

	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int GAIN_BITS        = 15;
	localparam int GAIN_SHIFT       = 7;
	localparam int APB_DATA_W       = 32;
	localparam int APB_ADDR_W       = 4;

	localparam logic [GAIN_BITS-1:0] GAIN_CUR_RST  = 15'd1701;
	localparam logic [GAIN_BITS-1:0] GAIN_PREV_RST = 15'd857;
	localparam logic [GAIN_BITS-1:0] GAIN_OLD_RST  = 15'd0;

	typedef enum logic [1:0] {
		REG_GAIN_CUR  = 2'd0,
		REG_GAIN_PREV = 2'd1,
		REG_GAIN_OLD  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_BITS-1:0] cur;
		logic [GAIN_BITS-1:0] prev;
		logic [GAIN_BITS-1:0] old;
	} gains_t;

endpackage

// File: sv/ipid_if.sv
// Valid/ready channel interfaces for the incremental PID block.
// Standalone; widths set by the sample width parameter.
interface ipid_cmd_if #(parameter int W = 16) ();
	logic                valid;
	logic                ready;
	logic                req_type;
	logic signed [W-1:0] target;
	logic signed [W-1:0] measured;
	logic signed [W-1:0] prior_drive;

	modport source (output valid, req_type, target, measured, prior_drive, input ready);
	modport sink   (input valid, req_type, target, measured, prior_drive, output ready);
endinterface

interface ipid_res_if #(parameter int W = 16) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] drive;

	modport source (output valid, drive, input ready);
	modport sink   (input valid, drive, output ready);
endinterface

// File: sv/ipid_cfg.sv
// APB gain register file for the incremental PID block.
// Depends on ipid_pkg.
module ipid_cfg
	import ipid_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output gains_t                gains
);

	gains_t   gains_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign gains  = gains_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.cur  <= GAIN_CUR_RST;
			gains_q.prev <= GAIN_PREV_RST;
			gains_q.old  <= GAIN_OLD_RST;
		end else if (wr_en) begin
			case (idx)
				REG_GAIN_CUR:  gains_q.cur  <= pwdata[GAIN_BITS-1:0];
				REG_GAIN_PREV: gains_q.prev <= pwdata[GAIN_BITS-1:0];
				REG_GAIN_OLD:  gains_q.old  <= pwdata[GAIN_BITS-1:0];
				default: ;  // unmapped slot, write dropped
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_GAIN_CUR:  prdata = {{(APB_DATA_W-GAIN_BITS){1'b0}}, gains_q.cur};
			REG_GAIN_PREV: prdata = {{(APB_DATA_W-GAIN_BITS){1'b0}}, gains_q.prev};
			REG_GAIN_OLD:  prdata = {{(APB_DATA_W-GAIN_BITS){1'b0}}, gains_q.old};
			default:       prdata = '0;
		endcase
	end

endmodule

// File: sv/ipid_calc.sv
// Combinational PID update: error, three scaled terms, wrapped drive sum.
// Depends on ipid_pkg.
module ipid_calc
	import ipid_pkg::*;
#(
	parameter int W = SAMPLE_WIDTH_DEF
) (
	input  gains_t              gains,
	input  logic                req_type,
	input  logic signed [W-1:0] target,
	input  logic signed [W-1:0] measured,
	input  logic signed [W-1:0] prior_drive,
	input  logic signed [W-1:0] prev_err,
	input  logic signed [W-1:0] older_err,
	input  logic signed [W-1:0] last_drive,
	output logic signed [W-1:0] err,
	output logic signed [W-1:0] drive
);

	localparam int PW = W + GAIN_BITS + 1;

	logic signed [PW-1:0] p_cur, p_prev, p_old;
	logic signed [W-1:0]  t_cur, t_prev, t_old, base;

	assign err = target - measured;

	// gains are unsigned: zero-extend one bit so the multiply stays signed
	assign p_cur  = $signed({1'b0, gains.cur})  * err;
	assign p_prev = $signed({1'b0, gains.prev}) * prev_err;
	assign p_old  = $signed({1'b0, gains.old})  * older_err;

	// floor shift then keep the low W bits
	assign t_cur  = p_cur[W+GAIN_SHIFT-1:GAIN_SHIFT];
	assign t_prev = p_prev[W+GAIN_SHIFT-1:GAIN_SHIFT];
	assign t_old  = p_old[W+GAIN_SHIFT-1:GAIN_SHIFT];

	assign base  = req_type ? prior_drive : last_drive;
	assign drive = base + t_cur - t_prev + t_old;

endmodule

// File: sv/incremental_pid_fixed_point.sv
// Top level of the velocity-form fixed-point PID controller.
// Depends on ipid_pkg, ipid_if, ipid_cfg, ipid_calc and the defines header.
//
//   channel  dir  handshake      payload
//   cmd      in   valid/ready    req_type, target, measured, prior_drive
//   res      out  valid/ready    drive
//   apb      in   psel/penable   gain registers at 0x0, 0x4, 0x8
//
// One item per cycle while res.ready holds; an accepted item passes the input
// register, then the result register, before its result is valid.
// The critical path is the three gain multiplies feeding the four-input add.
// arst_n clears the valid bits, the error history and the stored drive, and
// loads the reset gains.
// A stalled result holds in the result register while one more item waits in
// the input register; only then does cmd.ready drop.
`include "incremental_pid_fixed_point_defines.svh"
module incremental_pid_fixed_point
	import ipid_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	ipid_cmd_if.sink              cmd,
	ipid_res_if.source            res
);

	localparam int W = SAMPLE_WIDTH;

	gains_t gains;

	// input register
	logic                valid_s1;
	logic                req_type_s1;
	logic signed [W-1:0] target_s1, measured_s1, prior_drive_s1;

	// result register
	logic                valid_s2;
	logic signed [W-1:0] drive_s2;

	// controller state, updated as an item leaves the input register
	logic signed [W-1:0] prev_err_q, older_err_q, last_drive_q;

	logic signed [W-1:0] err, drive;
	logic                adv;

	ipid_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.gains   (gains)
	);

	ipid_calc #(.W(W)) u_calc (
		.gains       (gains),
		.req_type    (req_type_s1),
		.target      (target_s1),
		.measured    (measured_s1),
		.prior_drive (prior_drive_s1),
		.prev_err    (prev_err_q),
		.older_err   (older_err_q),
		.last_drive  (last_drive_q),
		.err         (err),
		.drive       (drive)
	);

	// item moves on when the result register is empty or being drained
	assign adv       = valid_s1 && (!valid_s2 || res.ready);
	assign cmd.ready = !valid_s1 || adv;
	assign res.valid = valid_s2;
	assign res.drive = drive_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			req_type_s1    <= cmd.req_type;
			target_s1      <= cmd.target;
			measured_s1    <= cmd.measured;
			prior_drive_s1 <= cmd.prior_drive;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drive_s2 <= drive;
		end
	end

	// history always shifts; stored drive only follows mode 0 items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q   <= '0;
			older_err_q  <= '0;
			last_drive_q <= '0;
		end else if (adv) begin
			prev_err_q  <= err;
			older_err_q <= prev_err_q;
			if (!req_type_s1) begin
				last_drive_q <= drive;
			end
		end
	end

	`IPID_ASSERT_NOW(a_stall_only_when_full, !cmd.ready, valid_s1 && valid_s2 && !res.ready)
	`IPID_ASSERT_NEXT(a_mode0_keeps_drive, adv && !req_type_s1, last_drive_q == drive_s2)
	`IPID_ASSERT_NEXT(a_mode1_holds_drive, adv && req_type_s1, $stable(last_drive_q))
	`IPID_ASSERT_NEXT(a_history_shifts, adv, older_err_q == $past(prev_err_q))

endmodule

// File: sim/incremental_pid_fixed_point_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for incremental_pid_fixed_point: predicts each drive item
// from the command stream and the gain writes. Needs ipid_pkg, ipid_if and the RTL.
import ipid_pkg::*;

// Base selection for one command
typedef enum bit {
	MODE_STORED = 1'b0,	// base is the stored drive, which then takes the new drive
	MODE_PRIOR  = 1'b1	// base is the supplied prior drive, stored drive untouched
} drive_mode_t;

typedef struct {
	drive_mode_t                        mode;
	logic signed [SAMPLE_WIDTH_DEF-1:0] target;
	logic signed [SAMPLE_WIDTH_DEF-1:0] measured;
	logic signed [SAMPLE_WIDTH_DEF-1:0] prior_drive;
} pid_cmd_t;

// Tracks gains, error history and stored drive; queues the drives to come.
class pid_drive_tracker;
	gains_t                             gain;
	logic signed [SAMPLE_WIDTH_DEF-1:0] prev_err;
	logic signed [SAMPLE_WIDTH_DEF-1:0] older_err;
	logic signed [SAMPLE_WIDTH_DEF-1:0] last_drive;
	logic signed [SAMPLE_WIDTH_DEF-1:0] pending_drives[$];
	int                                 mismatches;

	function new();
		gain.cur   = GAIN_CUR_RST;
		gain.prev  = GAIN_PREV_RST;
		gain.old   = GAIN_OLD_RST;
		prev_err   = '0;
		older_err  = '0;
		last_drive = '0;
		mismatches = 0;
	endfunction

	// Only the low gain bits are kept; unmapped indexes change nothing
	function void set_gain(int idx, logic [APB_DATA_W-1:0] data);
		case (idx)
			REG_GAIN_CUR:  gain.cur  = data[GAIN_BITS-1:0];
			REG_GAIN_PREV: gain.prev = data[GAIN_BITS-1:0];
			REG_GAIN_OLD:  gain.old  = data[GAIN_BITS-1:0];
			default: ;
		endcase
	endfunction

	// gain * error, floor-shifted, then cut to the sample width
	static function logic [SAMPLE_WIDTH_DEF-1:0] scaled_term(logic [GAIN_BITS-1:0] g,
			logic signed [SAMPLE_WIDTH_DEF-1:0] e);
		int prod;
		int shifted;
		prod    = int'(g) * int'(e);
		shifted = prod >>> GAIN_SHIFT;
		return shifted[SAMPLE_WIDTH_DEF-1:0];
	endfunction

	function void note_command(pid_cmd_t c);
		logic signed [SAMPLE_WIDTH_DEF-1:0] err;
		logic signed [SAMPLE_WIDTH_DEF-1:0] base;
		logic signed [SAMPLE_WIDTH_DEF-1:0] drive;
		err   = c.target - c.measured;
		base  = (c.mode == MODE_PRIOR) ? c.prior_drive : last_drive;
		drive = base + scaled_term(gain.cur, err) - scaled_term(gain.prev, prev_err)
			+ scaled_term(gain.old, older_err);
		older_err = prev_err;
		prev_err  = err;
		if (c.mode == MODE_STORED)
			last_drive = drive;
		pending_drives.push_back(drive);
	endfunction

	function void check_drive(logic signed [SAMPLE_WIDTH_DEF-1:0] got);
		logic signed [SAMPLE_WIDTH_DEF-1:0] want;
		if (pending_drives.size() == 0) begin
			$display("%0t: drive item with none expected, actual %0d", $time, got);
			mismatches++;
			return;
		end
		want = pending_drives.pop_front();
		if (got !== want) begin
			$display("%0t: drive mismatch, expected %0d actual %0d", $time, want, got);
			mismatches++;
		end
	endfunction

	function int pending();
		return pending_drives.size();
	endfunction
endclass

module incremental_pid_fixed_point_tb;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 8;
	localparam int LATENCY      = 2;	// input register, then result register
	localparam int SEGMENTS     = 7;
	localparam int SEG_ITEMS    = 200;
	localparam int HOLD_CYCLES  = 80;
	localparam int UNMAPPED_REG = 3;	// first index past the gain registers
	localparam int TIMEOUT_NS   = 2_000_000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	ipid_cmd_if #(.W(SAMPLE_WIDTH_DEF)) cmd_ch ();
	ipid_res_if #(.W(SAMPLE_WIDTH_DEF)) res_ch ();

	incremental_pid_fixed_point #(.SAMPLE_WIDTH(SAMPLE_WIDTH_DEF)) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cmd     (cmd_ch),
		.res     (res_ch)
	);

	pid_drive_tracker tracker = new();

	// Idle odds in percent, changed by the stimulus between segments
	int send_idle_pct = 10;
	int recv_idle_pct = 65;
	// Set by the stimulus; the receiver turns it into a long stall
	bit hold_request  = 1'b0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Hard stop in case the block wedges
	initial begin
		#(TIMEOUT_NS);
		$display("Test completed with failures");
		$finish;
	end

	// Result side: values read right after the edge are the pre-edge ones,
	// so valid && ready here means an item moved at this edge.
	initial begin : drive_receiver
		int hold_left;
		hold_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready)
				tracker.check_drive(res_ch.drive);
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (hold_request) begin
				// long stall: input register and result register both fill,
				// then cmd.ready has to drop
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offers one command and returns at the edge that takes it. valid stays
	// high on return so back-to-back items never toggle it within one step.
	task automatic send_command(pid_cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid       <= 1'b1;
		cmd_ch.req_type    <= c.mode;
		cmd_ch.target      <= c.target;
		cmd_ch.measured    <= c.measured;
		cmd_ch.prior_drive <= c.prior_drive;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		tracker.note_command(c);
	endtask

	task automatic send_fields(drive_mode_t mode, logic signed [15:0] target,
			logic signed [15:0] measured, logic signed [15:0] prior_drive);
		pid_cmd_t c;
		c.mode        = mode;
		c.target      = target;
		c.measured    = measured;
		c.prior_drive = prior_drive;
		send_command(c);
	endtask

	// Mostly a loop tracking near its setpoint, sometimes a wild sample
	function automatic pid_cmd_t random_command();
		pid_cmd_t                           c;
		logic signed [SAMPLE_WIDTH_DEF-1:0] delta;
		c.mode        = drive_mode_t'($urandom_range(1));
		c.target      = SAMPLE_WIDTH_DEF'($urandom);
		c.prior_drive = SAMPLE_WIDTH_DEF'($urandom);
		if ($urandom_range(3) == 0) begin
			c.measured = SAMPLE_WIDTH_DEF'($urandom);
		end else begin
			delta      = SAMPLE_WIDTH_DEF'($urandom_range(511));
			c.measured = c.target + delta - 16'sd256;
		end
		return c;
	endfunction

	// Wait for the last drive, then give the pipeline time to settle
	task automatic drain_results();
		cmd_ch.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes pwdata at the edge
	// where the access phase sees pready.
	task automatic write_gain(int idx, logic [APB_DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'(idx << 2);
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.set_gain(idx, data);
	endtask

	// Gains per segment: both extremes (with junk in the unused high bits),
	// small gains, mixed extremes and fully random words.
	task automatic load_segment_gains(int seg);
		logic [APB_DATA_W-1:0] g_cur;
		logic [APB_DATA_W-1:0] g_prev;
		logic [APB_DATA_W-1:0] g_old;
		g_cur  = $urandom;
		g_prev = $urandom;
		g_old  = $urandom;
		case (seg)
			0: begin
				g_cur  = 32'hFFFF_FFFF;
				g_prev = 32'hFFFF_FFFF;
				g_old  = 32'hFFFF_FFFF;
			end
			1: begin
				g_cur  = 32'hFFFF_8000;
				g_prev = 32'hFFFF_8000;
				g_old  = 32'hFFFF_8000;
			end
			3: begin
				g_cur  = $urandom_range(255);
				g_prev = $urandom_range(255);
				g_old  = $urandom_range(255);
			end
			5: begin
				g_cur  = 32'h0000_7FFF;
				g_prev = 32'h0000_0000;
			end
			default: ;
		endcase
		write_gain(REG_GAIN_CUR, g_cur);
		write_gain(REG_GAIN_PREV, g_prev);
		write_gain(REG_GAIN_OLD, g_old);
		write_gain(UNMAPPED_REG, $urandom);
	endtask

	initial begin : stimulus
		arst_n               <= 1'b0;
		psel                 <= 1'b0;
		penable              <= 1'b0;
		pwrite               <= 1'b0;
		paddr                <= '0;
		pwdata               <= '0;
		cmd_ch.valid         <= 1'b0;
		cmd_ch.req_type      <= MODE_STORED;
		cmd_ch.target        <= '0;
		cmd_ch.measured      <= '0;
		cmd_ch.prior_drive   <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (LATENCY) @(posedge clk);

		// Directed, reset gains first: error wrap both ways, term overflow,
		// prior drive at its extremes, prior drive ignored in stored mode,
		// and alternating bit patterns on every field.
		send_fields(MODE_STORED, 16'sd0, 16'sd0, 16'sd0);
		send_fields(MODE_STORED, 16'sd32767, -16'sd32768, 16'sd0);
		send_fields(MODE_STORED, -16'sd32768, 16'sd32767, 16'sd0);
		send_fields(MODE_STORED, 16'sd32767, 16'sd0, 16'sd0);
		send_fields(MODE_STORED, -16'sd32768, 16'sd0, 16'sd0);
		send_fields(MODE_PRIOR, 16'sd100, 16'sd50, 16'sd32767);
		send_fields(MODE_PRIOR, 16'sd0, 16'sd0, -16'sd32768);
		send_fields(MODE_STORED, 16'sd10, 16'sd20, -16'sd1);
		send_fields(MODE_PRIOR, -16'sd1, 16'sd1, 16'sd0);
		send_fields(MODE_STORED, 16'sh5555, 16'shAAAA, 16'sh5555);
		send_fields(MODE_PRIOR, 16'shAAAA, 16'sh5555, 16'shAAAA);
		send_fields(MODE_STORED, 16'sd1, 16'sd0, 16'sd0);
		send_fields(MODE_STORED, 16'sd1000, -16'sd1000, 16'sd0);
		drain_results();

		// Largest gains against extreme inputs: some terms overflow
		write_gain(REG_GAIN_CUR, 32'hFFFF_FFFF);
		write_gain(REG_GAIN_PREV, 32'h0000_7FFF);
		write_gain(REG_GAIN_OLD, 32'h0000_7FFF);
		write_gain(UNMAPPED_REG, 32'h0000_1234);
		send_fields(MODE_STORED, 16'sd32767, -16'sd32768, 16'sd0);
		send_fields(MODE_STORED, -16'sd32768, 16'sd32767, 16'sd0);
		send_fields(MODE_STORED, 16'sd32767, 16'sd32767, 16'sd0);
		send_fields(MODE_PRIOR, 16'sd12345, -16'sd12345, 16'sd32767);
		send_fields(MODE_STORED, 16'sd0, 16'sd1, 16'sd0);
		send_fields(MODE_PRIOR, -16'sd32768, 16'sd0, -16'sd32768);
		drain_results();

		// Random segments: receiver sparse first, then sender sparse,
		// then both flat out with long result stalls thrown in.
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			if (seg < 2) begin
				send_idle_pct = 10;
				recv_idle_pct = 65;
			end else if (seg < 4) begin
				send_idle_pct = 65;
				recv_idle_pct = 10;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			load_segment_gains(seg);
			for (int n = 0; n < SEG_ITEMS; n++) begin
				if ((seg == 4 || seg == 6) && n == SEG_ITEMS / 2)
					hold_request = 1'b1;
				send_command(random_command());
			end
			drain_results();
		end

		repeat (LATENCY + 4) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+sv
sv/ipid_pkg.sv
sv/ipid_if.sv
sv/ipid_cfg.sv
sv/ipid_calc.sv
sv/incremental_pid_fixed_point.sv
sim/incremental_pid_fixed_point_tb.sv
